[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[hdl/bsf_pkg.sv]
package bsf_pkg;

    // Result kind codes
    localparam logic [1:0] KIND_FLAG    = 2'd0;
    localparam logic [1:0] KIND_ESCAPE  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_PARITY  = 2'd3;

    // Register indexes and reset values
    localparam logic REG_FLAG   = 1'b0;
    localparam logic REG_ESCAPE = 1'b1;
    localparam logic [7:0] FLAG_RESET   = 8'd36;
    localparam logic [7:0] ESCAPE_RESET = 8'd47;

    // Depth of the request queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] flag_value;
        logic [7:0] escape_value;
    } t_cfg;

    // One classified request: the byte and the frame bytes it calls for
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       open_frame;
        logic       needs_escape;
        logic       last_byte;
    } t_cmd;

endpackage

[hdl/byte_stuff_framer_parity.sv]
// Byte-stuffing framer with trailing parity. Each payload byte pushed in comes
// out as one to five frame bytes: an opening flag on the first byte of a
// message, an escape ahead of any byte equal to the flag or escape register,
// the byte itself, and after the last byte a closing flag and a parity byte
// (XOR of all frame bytes of the message, flags and escapes included).
// out_last marks the final frame byte produced for each pushed byte. The
// front classifies a byte in the cycle it is pushed and hands it to a
// QUEUE_DEPTH-entry request queue; the back sequencer drains it at one frame
// byte per cycle while its output slot is free or being popped. Pushes are
// taken while the queue has room, independent of a waiting result. Write
// flag_value at address 0 and escape_value at address 4 only while idle.
module byte_stuff_framer_parity
    import bsf_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_out_kind,
    output logic        o_out_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg w_cfg;
    logic w_q_push;
    t_cmd w_q_wdata;
    logic w_q_full;
    logic w_q_pop;
    logic w_q_valid;
    t_cmd w_q_rdata;

    assign full = w_q_full;

    bsf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bsf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_payload_byte (i_payload_byte),
        .i_last_byte    (i_last_byte),
        .i_cfg          (w_cfg),
        .i_q_full       (w_q_full),
        .o_q_push       (w_q_push),
        .o_q_data       (w_q_wdata)
    );

    bsf_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_rdata)
    );

    bsf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_q_valid  (w_q_valid),
        .i_q_data   (w_q_rdata),
        .o_q_pop    (w_q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_byte (o_out_byte),
        .o_out_kind (o_out_kind),
        .o_out_last (o_out_last)
    );

endmodule

[hdl/bsf_regs.sv]
module bsf_regs
    import bsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [7:0] r_flag;
    logic [7:0] r_escape;
    logic       w_wr;
    logic       w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[2];

    // Hold the flag and escape registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag   <= FLAG_RESET;
            r_escape <= ESCAPE_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_FLAG:   r_flag   <= pwdata[7:0];
                REG_ESCAPE: r_escape <= pwdata[7:0];
                default:    r_flag   <= r_flag;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (w_idx)
            REG_FLAG:   prdata = {24'd0, r_flag};
            REG_ESCAPE: prdata = {24'd0, r_escape};
            default:    prdata = 32'd0;
        endcase
    end

    assign o_cfg.flag_value   = r_flag;
    assign o_cfg.escape_value = r_escape;

endmodule

[hdl/bsf_front.sv]
module bsf_front
    import bsf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_payload_byte,
    input  logic       i_last_byte,
    input  t_cfg       i_cfg,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_cmd       o_q_data
);

    logic r_in_frame;

    assign o_q_push = i_push && !i_q_full;

    // Classify the byte: opening flag needed, escape needed
    always_comb begin
        o_q_data.payload_byte = i_payload_byte;
        o_q_data.open_frame   = !r_in_frame;
        o_q_data.needs_escape = (i_payload_byte == i_cfg.flag_value) ||
                                (i_payload_byte == i_cfg.escape_value);
        o_q_data.last_byte    = i_last_byte;
    end

    // Track whether a frame is open
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
        end else if (o_q_push) begin
            r_in_frame <= !i_last_byte;
        end
    end

endmodule

[hdl/bsf_queue.sv]
module bsf_queue
    import bsf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [AW:0]     r_count;
    logic            w_wr;
    logic            w_rd;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    // Store requests
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hdl/bsf_back.sv]
module bsf_back
    import bsf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_valid,
    input  t_cmd       i_q_data,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_out_kind,
    output logic       o_out_last
);

    typedef enum logic [2:0] {
        PH_OPEN,
        PH_ESC,
        PH_PAY,
        PH_CLOSE,
        PH_PAR
    } t_phase;

    t_phase     r_phase;
    logic       r_mid;
    logic [7:0] r_parity;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic [1:0] r_out_kind;
    logic       r_out_last;

    t_phase     w_first;
    t_phase     w_cur;
    t_phase     w_nxt;
    logic [7:0] w_byte;
    logic [1:0] w_kind;
    logic       w_fin;
    logic       w_go;

    // Pick the phase the head request starts in
    always_comb begin
        if (i_q_data.open_frame) begin
            w_first = PH_OPEN;
        end else if (i_q_data.needs_escape) begin
            w_first = PH_ESC;
        end else begin
            w_first = PH_PAY;
        end
        w_cur = r_mid ? r_phase : w_first;
    end

    // Produce the byte for the current phase and the phase after it
    always_comb begin
        unique case (w_cur)
            PH_OPEN: begin
                w_byte = i_cfg.flag_value;
                w_kind = KIND_FLAG;
                w_fin  = 1'b0;
                w_nxt  = i_q_data.needs_escape ? PH_ESC : PH_PAY;
            end
            PH_ESC: begin
                w_byte = i_cfg.escape_value;
                w_kind = KIND_ESCAPE;
                w_fin  = 1'b0;
                w_nxt  = PH_PAY;
            end
            PH_PAY: begin
                w_byte = i_q_data.payload_byte;
                w_kind = KIND_PAYLOAD;
                w_fin  = !i_q_data.last_byte;
                w_nxt  = PH_CLOSE;
            end
            PH_CLOSE: begin
                w_byte = i_cfg.flag_value;
                w_kind = KIND_FLAG;
                w_fin  = 1'b0;
                w_nxt  = PH_PAR;
            end
            PH_PAR: begin
                w_byte = r_parity;
                w_kind = KIND_PARITY;
                w_fin  = 1'b1;
                w_nxt  = PH_PAY;
            end
            default: begin
                w_byte = i_q_data.payload_byte;
                w_kind = KIND_PAYLOAD;
                w_fin  = 1'b1;
                w_nxt  = PH_PAY;
            end
        endcase
    end

    // Emit when the output slot is free or being drained
    assign w_go    = i_q_valid && (!r_out_valid || i_pop);
    assign o_q_pop = w_go && w_fin;

    // Hold sequencer state, running parity and the output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PAY;
            r_mid       <= 1'b0;
            r_parity    <= 8'd0;
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= 1'b1;
            r_out_byte  <= w_byte;
            r_out_kind  <= w_kind;
            r_out_last  <= w_fin;
            r_mid       <= !w_fin;
            r_phase     <= w_nxt;
            if (w_cur == PH_PAR) begin
                r_parity <= 8'd0;
            end else if (w_cur == PH_OPEN) begin
                r_parity <= w_byte;
            end else begin
                r_parity <= r_parity ^ w_byte;
            end
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_out_kind = r_out_kind;
    assign o_out_last = r_out_last;

endmodule

[hdl/bsf_checker.sv]
`include "assert_macros.svh"

module bsf_checker
    import bsf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic [7:0]  i_payload_byte,
    input logic        i_last_byte,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  o_out_byte,
    input logic [1:0]  o_out_kind,
    input logic        o_out_last,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // A waiting result holds until taken
    `ASSERT_CLK(a_hold, (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_out_kind)), "result changed while stalled")

    // A parity byte always closes the run of its request
    `ASSERT_CLK(a_par_last, (!empty && (o_out_kind == KIND_PARITY)) |-> o_out_last, "parity byte not marked last")

    // An escape is always followed by its payload byte in the same run
    `ASSERT_CLK(a_esc_not_last, (!empty && (o_out_kind == KIND_ESCAPE)) |-> !o_out_last, "escape marked last")

    // Nothing is shown in the cycle after reset
    `ASSERT_CLK(a_reset_empty, !$past(i_rst_n) |-> empty, "result shown after reset")

endmodule

bind byte_stuff_framer_parity bsf_checker u_chk (.*);

[tb/byte_stuff_framer_parity_tb.sv]
`timescale 1ns / 1ps

module byte_stuff_framer_parity_tb;
    import bsf_pkg::*;

    localparam int N_DIRECTED   = 15;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 32;
    localparam int LONG_HOLD    = 60;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    // One frame byte as it leaves the block
    typedef struct packed {
        logic [7:0] value;
        logic [1:0] kind;
        logic       last;
    } t_frame_byte;

    // Directed stimulus row; n_typed > 0 gives the frame bytes written out by hand
    typedef struct packed {
        logic [7:0]      payload;
        logic            last;
        logic [2:0]      n_typed;
        logic [0:4][7:0] bytes;
        logic [0:4][1:0] kinds;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_payload_byte;
    logic        i_last_byte;
    logic        empty;
    logic        pop;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_out_kind;
    logic        o_out_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Framer model state and its copy of the registers
    logic [7:0]  model_flag   = FLAG_RESET;
    logic [7:0]  model_escape = ESCAPE_RESET;
    logic        frame_open   = 1'b0;
    logic [7:0]  frame_parity = 8'h00;
    t_frame_byte stuffed[0:4];
    int          n_stuffed;

    t_frame_byte pending_frame_bytes[$];
    t_stim_row   dir_tab[0:N_DIRECTED-1];
    int          cur_row;
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          fast_tx = 1'b0;
    bit          long_hold_req = 1'b0;

    byte_stuff_framer_parity uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_payload_byte (i_payload_byte),
        .i_last_byte    (i_last_byte),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_out_kind     (o_out_kind),
        .o_out_last     (o_out_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    // Add one frame byte to the tail of the expected list
    task automatic queue_expected(input t_frame_byte fb);
        pending_frame_bytes = {pending_frame_bytes, fb};
    endtask

    // Append one frame byte; everything but the parity byte feeds the parity
    task automatic emit_frame_byte(input logic [7:0] value, input logic [1:0] kind);
        stuffed[n_stuffed] = '{value, kind, 1'b0};
        if (kind != KIND_PARITY)
            frame_parity = frame_parity ^ value;
        n_stuffed++;
    endtask

    // Work out the frame bytes that one payload byte produces
    task automatic stuff_byte(input logic [7:0] b, input logic l);
        n_stuffed = 0;
        if (!frame_open) begin
            frame_open = 1'b1;
            frame_parity = 8'h00;
            emit_frame_byte(model_flag, KIND_FLAG);
        end
        if (b == model_flag || b == model_escape)
            emit_frame_byte(model_escape, KIND_ESCAPE);
        emit_frame_byte(b, KIND_PAYLOAD);
        if (l) begin
            emit_frame_byte(model_flag, KIND_FLAG);
            emit_frame_byte(frame_parity, KIND_PARITY);
            frame_open = 1'b0;
            frame_parity = 8'h00;
        end
        stuffed[n_stuffed-1].last = 1'b1;
    endtask

    // Check popped bytes, predict pushed bytes, track register writes
    always @(posedge i_clk) begin : monitor
        t_frame_byte got;
        t_frame_byte want;
        int r;
        if (i_rst_n) begin
            if (pop && !empty) begin
                got = '{o_out_byte, o_out_kind, o_out_last};
                if (pending_frame_bytes.size() == 0) begin
                    note_mismatch("unexpected frame byte", 32'h0, {21'h0, got});
                end else begin
                    want = pending_frame_bytes.pop_front();
                    if (got.value !== want.value)
                        note_mismatch("out_byte", 32'(want.value), 32'(got.value));
                    if (got.kind !== want.kind)
                        note_mismatch("out_kind", 32'(want.kind), 32'(got.kind));
                    if (got.last !== want.last)
                        note_mismatch("out_last", 32'(want.last), 32'(got.last));
                end
            end
            if (push && !full) begin
                stuff_byte(i_payload_byte, i_last_byte);
                r = cur_row;
                if (r >= 0 && dir_tab[r].n_typed != 0) begin
                    for (int i = 0; i < dir_tab[r].n_typed; i++) begin
                        want = '{dir_tab[r].bytes[i], dir_tab[r].kinds[i],
                                 i == dir_tab[r].n_typed - 1};
                        queue_expected(want);
                    end
                end else begin
                    for (int i = 0; i < n_stuffed; i++)
                        queue_expected(stuffed[i]);
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_FLAG)
                    model_flag = pwdata[7:0];
                else
                    model_escape = pwdata[7:0];
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Result side: random stalls, fast stretches, and one long hold-off
    initial begin : result_side
        int rx_wait;
        int n_popped;
        rx_wait = 0;
        n_popped = 0;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                rx_wait = LONG_HOLD;
            end
            if (rx_wait > 0) begin
                pop <= 1'b0;
                rx_wait--;
            end else begin
                pop <= 1'b1;
            end
            @(posedge i_clk);
            if (pop && !empty) begin
                n_popped++;
                rx_wait = ((n_popped / 40) % 3 == 1) ? 0 : $urandom_range(0, 9);
            end
        end
    end

    // Offer one payload byte after a random gap, or none in fast mode, and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic l, input int row);
        int gap;
        gap = fast_tx ? 0 : $urandom_range(0, 9);
        repeat (gap) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_payload_byte <= b;
        i_last_byte <= l;
        cur_row <= row;
        @(posedge i_clk);
        while (!(push && !full))
            @(posedge i_clk);
    endtask

    // Stop offering and wait for every predicted frame byte to drain
    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_frame_bytes.size() != 0)
            @(negedge i_clk);
    endtask

    // Write one register, then read it back
    task automatic cfg_write(input logic idx, input logic [7:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'h0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata !== {24'h0, value})
            note_mismatch("register readback", {24'h0, value}, prdata);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin : stimulus
        logic [7:0] ph_flag;
        logic [7:0] ph_escape;
        logic [7:0] b;
        logic       l;

        i_rst_n = 1'b0;
        push = 1'b0;
        i_payload_byte = 8'h00;
        i_last_byte = 1'b0;
        cur_row = -1;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;

        // Reset-value registers: flag 0x24, escape 0x2F
        dir_tab[0]  = '{8'h00, 1'b1, 3'd4, {8'h24, 8'h00, 8'h24, 8'h00, 8'h00},
                        {KIND_FLAG, KIND_PAYLOAD, KIND_FLAG, KIND_PARITY, KIND_FLAG}};
        dir_tab[1]  = '{8'h24, 1'b1, 3'd5, {8'h24, 8'h2F, 8'h24, 8'h24, 8'h0B},
                        {KIND_FLAG, KIND_ESCAPE, KIND_PAYLOAD, KIND_FLAG, KIND_PARITY}};
        dir_tab[2]  = '{8'hFF, 1'b0, 3'd2, {8'h24, 8'hFF, 8'h00, 8'h00, 8'h00},
                        {KIND_FLAG, KIND_PAYLOAD, KIND_FLAG, KIND_FLAG, KIND_FLAG}};
        dir_tab[3]  = '{8'h2F, 1'b1, 3'd4, {8'h2F, 8'h2F, 8'h24, 8'hFF, 8'h00},
                        {KIND_ESCAPE, KIND_PAYLOAD, KIND_FLAG, KIND_PARITY, KIND_FLAG}};
        dir_tab[4]  = '{8'h80, 1'b0, 3'd0, '0, '0};
        dir_tab[5]  = '{8'h7F, 1'b0, 3'd0, '0, '0};
        dir_tab[6]  = '{8'h55, 1'b0, 3'd0, '0, '0};
        dir_tab[7]  = '{8'hAA, 1'b0, 3'd0, '0, '0};
        dir_tab[8]  = '{8'h24, 1'b0, 3'd0, '0, '0};
        dir_tab[9]  = '{8'h2F, 1'b0, 3'd0, '0, '0};
        dir_tab[10] = '{8'h01, 1'b1, 3'd0, '0, '0};
        dir_tab[11] = '{8'h2F, 1'b0, 3'd0, '0, '0};
        dir_tab[12] = '{8'hFE, 1'b1, 3'd0, '0, '0};
        dir_tab[13] = '{8'h24, 1'b0, 3'd0, '0, '0};
        dir_tab[14] = '{8'h24, 1'b1, 3'd0, '0, '0};

        // Hold reset, then release it on a falling edge
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (int k = 0; k < N_DIRECTED; k++)
            send_byte(dir_tab[k].payload, dir_tab[k].last, k);
        wait_drained();

        // Random phases; a frame may stay open across a register change
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin ph_flag = 8'h00; ph_escape = 8'h00; end
                1: begin ph_flag = 8'hFF; ph_escape = 8'hFF; end
                2: begin ph_flag = 8'h00; ph_escape = 8'hFF; end
                3: begin ph_flag = 8'hFF; ph_escape = 8'h00; end
                4: begin ph_flag = FLAG_RESET; ph_escape = ESCAPE_RESET; end
                6: begin
                    ph_flag = 8'($urandom_range(0, 255));
                    ph_escape = ph_flag;
                end
                default: begin
                    ph_flag = 8'($urandom_range(0, 255));
                    ph_escape = 8'($urandom_range(0, 255));
                end
            endcase
            cfg_write(REG_FLAG, ph_flag);
            cfg_write(REG_ESCAPE, ph_escape);

            // Phase 2 backs up the block: receiver holds off, sender never pauses
            if (ph == 2) begin
                fast_tx = 1'b1;
                long_hold_req = 1'b1;
            end else begin
                fast_tx = ($urandom_range(0, 2) == 0);
            end

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                case ($urandom_range(0, 3))
                    0: b = ph_flag;
                    1: b = ph_escape;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                l = ($urandom_range(0, 3) == 0);
                send_byte(b, l, -1);
            end
            wait_drained();
        end

        // Let any stray frame bytes show up
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_frame_bytes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
